FILE: sv/brbl_pkg.sv
package brbl_pkg;

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  real_size_cm;
      logic [9:0]  box_left;
      logic [10:0] box_width;
      logic [9:0]  box_height;
   } req_item_type;

   typedef struct packed {
      logic signed [15:0] pos_x_cm;
      logic signed [15:0] pos_y_cm;
      logic               saturated;
   } rsp_item_type;

   localparam logic [1:0] MODE_HEIGHT_CENTER = 2'd0;
   localparam logic [1:0] MODE_HEIGHT_RIGHT  = 2'd1;
   localparam logic [1:0] MODE_WIDTH_CENTER  = 2'd2;

   localparam logic CSR_BEARING_OFFSET = 1'b0;
   localparam logic CSR_HEADING_SIGN   = 1'b1;

   // Focal length over sensor size in Q1.16.
   localparam logic [16:0] K_HEIGHT = 17'd86169;
   localparam logic [16:0] K_WIDTH  = 17'd64233;
   // Horizontal field of view in 1/256 degree.
   localparam logic [13:0] FOV_Q8   = 14'd13696;
   localparam int TURN_Q8         = 92160;
   localparam int HALF_TURN_Q8    = 46080;
   localparam int QUARTER_TURN_Q8 = 23040;
   localparam logic [23:0] RANGE_MAX = 24'hFFFFFF;

   localparam int CORDIC_STEPS = 16;
   localparam int XY_W = 33;
   localparam int Z_W  = 25;
   localparam logic signed [XY_W-1:0] CORDIC_GAIN = 33'sd652032874;
   localparam logic signed [Z_W-1:0] ATAN_TAB [CORDIC_STEPS] = '{
      25'sd2949120, 25'sd1740967, 25'sd919879, 25'sd466945,
      25'sd234379,  25'sd117305,  25'sd58666,  25'sd29335,
      25'sd14668,   25'sd7334,    25'sd3667,   25'sd1833,
      25'sd917,     25'sd458,     25'sd229,    25'sd115
   };

   // Width of the bearing quotient; the bearing product itself stays below 2^26.
   localparam int BRG_W = 25;

   function automatic int brbl_num_w(int cols, int rows);
      int dim;
      dim = (cols > rows) ? cols : rows;
      return 25 + $clog2(dim + 1) - 8;
   endfunction

   function automatic int brbl_div_w(int cols, int rows);
      int n;
      n = brbl_num_w(cols, rows);
      return (n > BRG_W) ? n : BRG_W;
   endfunction

   function automatic int brbl_latency(int cols, int rows);
      return brbl_div_w(cols, rows) + CORDIC_STEPS + 6;
   endfunction

endpackage

FILE: sv/brbl_div_cell.sv
module brbl_div_cell
   import brbl_pkg::*;
#(
   parameter int W  = 30,
   parameter int DW = 13
) (
   input  logic          clock,
   input  logic [W-1:0]  q_i,
   input  logic [DW-1:0] rem_i,
   input  logic [DW-1:0] den_i,
   output logic [W-1:0]  q_ff,
   output logic [DW-1:0] rem_ff,
   output logic [DW-1:0] den_ff
);

   logic [DW:0]   trial;
   logic          ge;
   logic [W-1:0]  q_in;
   logic [DW-1:0] rem_in;

   // One restoring step: bring down the next dividend bit and try the divisor.
   always_comb begin
      trial  = {rem_i, q_i[W-1]};
      ge     = (trial >= {1'b0, den_i});
      rem_in = ge ? DW'(trial - {1'b0, den_i}) : DW'(trial);
      q_in   = {q_i[W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      q_ff   <= q_in;
      rem_ff <= rem_in;
      den_ff <= den_i;
   end

endmodule

FILE: sv/brbl_cordic_cell.sv
module brbl_cordic_cell
   import brbl_pkg::*;
#(
   parameter int STEP = 0
) (
   input  logic                   clock,
   input  logic signed [XY_W-1:0] x_i,
   input  logic signed [XY_W-1:0] y_i,
   input  logic signed [Z_W-1:0]  z_i,
   output logic signed [XY_W-1:0] x_ff,
   output logic signed [XY_W-1:0] y_ff,
   output logic signed [Z_W-1:0]  z_ff
);

   logic signed [XY_W-1:0] dx, dy, x_in, y_in;
   logic signed [Z_W-1:0]  z_in;

   always_comb begin
      dx = y_i >>> STEP;
      dy = x_i >>> STEP;
      if (!z_i[Z_W-1]) begin
         x_in = x_i - dx;
         y_in = y_i + dy;
         z_in = z_i - ATAN_TAB[STEP];
      end else begin
         x_in = x_i + dx;
         y_in = y_i - dy;
         z_in = z_i + ATAN_TAB[STEP];
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

endmodule

FILE: sv/box_range_bearing_locator.sv
// Box range and bearing locator.
//
// A host presents one bounding box item on req_item and raises start. The
// item is taken at every clock edge where start is high and busy is low; busy
// is never raised, so a new box may enter on every cycle.
// Each item yields exactly one result on rsp_item, shown for a single cycle
// with rsp_valid high. The receiver cannot hold results off, and nothing in
// the block waits on it, so there is no stall path at all.
// The pipeline holds two input stages, one cell per quotient bit in the divider
// chain (28 cells at the default frame size), two angle stages, sixteen CORDIC
// cells and two output stages. The divider chain length is the only part that
// varies with the frame size; throughput is one item per cycle.
// The csr channel writes the bearing offset (index 0) and heading sign
// (index 1); it is always ready and should only be used while no item is in
// flight. Synchronous reset empties the pipeline, sets the offset to zero and
// the heading sign to one.
module box_range_bearing_locator
   import brbl_pkg::*;
#(
   parameter int FRAME_COLS = 1024,
   parameter int FRAME_ROWS = 768
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_item,
   output logic         rsp_valid,
   output rsp_item_type rsp_item,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic         csr_index,
   input  logic [8:0]   csr_wdata
);

   localparam int NUM_W = brbl_num_w(FRAME_COLS, FRAME_ROWS);
   localparam int N_W   = NUM_W + 8;
   localparam int DIV_W = brbl_div_w(FRAME_COLS, FRAME_ROWS);
   localparam int DW    = ($clog2(FRAME_COLS + 1) > 11) ? $clog2(FRAME_COLS + 1) : 11;
   localparam int A_W   = 23;
   localparam int BIAS  = 16 * TURN_Q8;
   // Reciprocal of the frame width, exact for every bearing product below 2^26.
   localparam int BRG_S = 26 + $clog2(FRAME_COLS);
   localparam logic [26:0] BRG_M =
      27'(((64'd1 << BRG_S) + 64'(FRAME_COLS) - 64'd1) / 64'(FRAME_COLS));

   typedef struct packed {
      logic pix_zero;
      logic b_neg;
   } div_side_type;

   typedef struct packed {
      logic [23:0] range;
      logic        sat;
      logic        flip;
   } trig_side_type;

   // Configuration registers.
   logic signed [8:0] offset_ff;
   logic signed [1:0] heading_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff  <= '0;
         heading_ff <= 2'sd1;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_BEARING_OFFSET: offset_ff  <= csr_wdata;
            CSR_HEADING_SIGN:   heading_ff <= csr_wdata[1:0];
            default:            offset_ff  <= offset_ff;
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   logic accept;
   assign accept = start && !busy;

   // Stage 1: select range source and reference column.
   logic              is_w_in;
   logic [16:0]       k_in;
   logic [10:0]       pix_in;
   logic [11:0]       col_in;
   logic signed [13:0] pixoff_in;

   always_comb begin
      is_w_in = (req_item.mode == MODE_WIDTH_CENTER);
      k_in    = is_w_in ? K_WIDTH : K_HEIGHT;
      pix_in  = is_w_in ? req_item.box_width : {1'b0, req_item.box_height};
      if (req_item.mode == MODE_HEIGHT_RIGHT) begin
         col_in = {2'b0, req_item.box_left} + {1'b0, req_item.box_width};
      end else begin
         col_in = {2'b0, req_item.box_left} + {2'b0, req_item.box_width[10:1]};
      end
      pixoff_in = $signed({2'b0, col_in}) - 14'(FRAME_COLS / 2);
   end

   logic               v1_ff;
   logic [24:0]        kr_ff;
   logic [10:0]        pix_ff;
   logic               is_w_ff;
   logic signed [13:0] pixoff_ff;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else       v1_ff <= accept;
      kr_ff     <= k_in * req_item.real_size_cm;
      pix_ff    <= pix_in;
      is_w_ff   <= is_w_in;
      pixoff_ff <= pixoff_in;
   end

   // Stage 2: form the range dividend and the bearing product; these
   // registers feed the first cell.
   logic [N_W-1:0]   n_in;
   logic [11:0]      pmag_in;
   logic [25:0]      bprod_in;

   always_comb begin
      n_in     = N_W'(kr_ff) * (is_w_ff ? N_W'(FRAME_COLS) : N_W'(FRAME_ROWS));
      pmag_in  = pixoff_ff[13] ? 12'(-pixoff_ff) : 12'(pixoff_ff);
      bprod_in = pmag_in * FOV_Q8;
   end

   logic [DIV_W-1:0] rq_ff [0:DIV_W];
   logic [DW-1:0]    rr_ff [0:DIV_W];
   logic [DW-1:0]    rd_ff [0:DIV_W];
   logic [DIV_W-1:0] bq_ff [0:DIV_W];
   logic             dv_ff [0:DIV_W];
   div_side_type     ds_ff [0:DIV_W];
   logic [52:0]      brg_prod;

   always_ff @(posedge clock) begin
      if (reset) dv_ff[0] <= 1'b0;
      else       dv_ff[0] <= v1_ff;
      rq_ff[0] <= DIV_W'(n_in[N_W-1:8]);
      rr_ff[0] <= '0;
      rd_ff[0] <= DW'(pix_ff);
      bq_ff[0] <= DIV_W'(bprod_in);
      ds_ff[0] <= '{pix_zero: (pix_ff == '0), b_neg: pixoff_ff[13]};
   end

   // The bearing product is divided by the frame width with one reciprocal
   // multiply in the first cell; the quotient then rides along the chain.
   always_comb begin
      brg_prod = 53'(bq_ff[0][25:0]) * 53'(BRG_M);
   end

   // Divider chain: the range lane takes one quotient bit per cell.
   for (genvar i = 0; i < DIV_W; i++) begin : g_div
      brbl_div_cell #(.W(DIV_W), .DW(DW)) u_rng (
         .clock (clock),
         .q_i   (rq_ff[i]),   .rem_i (rr_ff[i]),   .den_i (rd_ff[i]),
         .q_ff  (rq_ff[i+1]), .rem_ff(rr_ff[i+1]), .den_ff(rd_ff[i+1])
      );
      always_ff @(posedge clock) begin
         if (reset) dv_ff[i+1] <= 1'b0;
         else       dv_ff[i+1] <= dv_ff[i];
         ds_ff[i+1] <= ds_ff[i];
         bq_ff[i+1] <= (i == 0) ? DIV_W'(brg_prod >> BRG_S) : bq_ff[i];
      end
   end

   // Stage 3: clip the range and reduce the bearing into one turn.
   logic [23:0]        range_in;
   logic               sat3_in;
   logic signed [A_W-1:0] ang_in;
   logic [A_W-1:0]     red_in;

   always_comb begin
      if (ds_ff[DIV_W].pix_zero || rq_ff[DIV_W] > DIV_W'(RANGE_MAX)) begin
         range_in = RANGE_MAX;
         sat3_in  = 1'b1;
      end else begin
         range_in = rq_ff[DIV_W][23:0];
         sat3_in  = 1'b0;
      end
      ang_in = A_W'(BIAS) + A_W'($signed({offset_ff, 8'b0}));
      if (ds_ff[DIV_W].b_neg) ang_in = ang_in - $signed(A_W'(bq_ff[DIV_W][BRG_W-1:0]));
      else                    ang_in = ang_in + $signed(A_W'(bq_ff[DIV_W][BRG_W-1:0]));
      // The bias keeps the sum positive; binary-weighted subtracts finish the modulo.
      red_in = ang_in;
      for (int j = 4; j >= 0; j--) begin
         if (red_in >= (A_W'(TURN_Q8) << j)) red_in = red_in - (A_W'(TURN_Q8) << j);
      end
   end

   logic        v3_ff;
   logic [23:0] range3_ff;
   logic        sat3_ff;
   logic [16:0] a3_ff;

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else       v3_ff <= dv_ff[DIV_W];
      range3_ff <= range_in;
      sat3_ff   <= sat3_in;
      a3_ff     <= red_in[16:0];
   end

   // Stage 4: fold into [-90, 90] degrees; a fold negates both results.
   logic signed [18:0]    fa_in;
   logic                  flip_in;
   logic signed [Z_W-1:0] z_in;

   always_comb begin
      fa_in   = $signed({2'b0, a3_ff});
      flip_in = 1'b0;
      if (fa_in > 19'sd46080) fa_in = fa_in - 19'(TURN_Q8);
      if (fa_in > 19'(QUARTER_TURN_Q8)) begin
         fa_in   = fa_in - 19'(HALF_TURN_Q8);
         flip_in = 1'b1;
      end else if (fa_in < -19'(QUARTER_TURN_Q8)) begin
         fa_in   = fa_in + 19'(HALF_TURN_Q8);
         flip_in = 1'b1;
      end
      z_in = {Z_W'(fa_in)} <<< 8;
   end

   logic signed [XY_W-1:0] cx_ff [0:CORDIC_STEPS];
   logic signed [XY_W-1:0] cy_ff [0:CORDIC_STEPS];
   logic signed [Z_W-1:0]  cz_ff [0:CORDIC_STEPS];
   logic                   cv_ff [0:CORDIC_STEPS];
   trig_side_type          cs_ff [0:CORDIC_STEPS];

   always_ff @(posedge clock) begin
      if (reset) cv_ff[0] <= 1'b0;
      else       cv_ff[0] <= v3_ff;
      cx_ff[0] <= CORDIC_GAIN;
      cy_ff[0] <= '0;
      cz_ff[0] <= z_in;
      cs_ff[0] <= '{range: range3_ff, sat: sat3_ff, flip: flip_in};
   end

   // CORDIC chain, one rotation per cell.
   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
      brbl_cordic_cell #(.STEP(i)) u_cell (
         .clock (clock),
         .x_i   (cx_ff[i]),   .y_i (cy_ff[i]),   .z_i (cz_ff[i]),
         .x_ff  (cx_ff[i+1]), .y_ff(cy_ff[i+1]), .z_ff(cz_ff[i+1])
      );
      always_ff @(posedge clock) begin
         if (reset) cv_ff[i+1] <= 1'b0;
         else       cv_ff[i+1] <= cv_ff[i];
         cs_ff[i+1] <= cs_ff[i];
      end
   end

   // Stage 5: range times sine and cosine.
   logic signed [XY_W-1:0] sin_in, cos_in;
   logic signed [24:0]     rng_s;

   always_comb begin
      sin_in = cs_ff[CORDIC_STEPS].flip ? -cy_ff[CORDIC_STEPS] : cy_ff[CORDIC_STEPS];
      cos_in = cs_ff[CORDIC_STEPS].flip ? -cx_ff[CORDIC_STEPS] : cx_ff[CORDIC_STEPS];
      rng_s  = $signed({1'b0, cs_ff[CORDIC_STEPS].range});
   end

   logic               v5_ff;
   logic               sat5_ff;
   logic signed [57:0] px_ff, py_ff;

   always_ff @(posedge clock) begin
      if (reset) v5_ff <= 1'b0;
      else       v5_ff <= cv_ff[CORDIC_STEPS];
      sat5_ff <= cs_ff[CORDIC_STEPS].sat;
      px_ff   <= rng_s * sin_in;
      py_ff   <= rng_s * cos_in;
   end

   // Stage 6: heading sign, truncation toward zero and clipping.
   typedef struct packed {
      logic signed [15:0] cm;
      logic               sat;
   } cm_type;

   function automatic cm_type to_cm(logic signed [57:0] p, logic signed [1:0] hs);
      logic signed [59:0] v;
      logic [59:0]        mag;
      logic [21:0]        m;
      cm_type             r;
      v   = p * hs;
      mag = v[59] ? 60'(-v) : 60'(v);
      m   = mag[59:38];
      r.sat = 1'b0;
      if (!v[59] && m > 22'd32767) begin
         r.cm  = 16'sh7FFF;
         r.sat = 1'b1;
      end else if (v[59] && m > 22'd32768) begin
         r.cm  = 16'sh8000;
         r.sat = 1'b1;
      end else begin
         r.cm = v[59] ? 16'(-m) : 16'(m);
      end
      return r;
   endfunction

   cm_type       cx_in, cy_in;
   rsp_item_type rsp_in;
   logic         rsp_valid_ff;
   rsp_item_type rsp_item_ff;

   always_comb begin
      cx_in = to_cm(px_ff, heading_ff);
      cy_in = to_cm(py_ff, heading_ff);
      rsp_in.pos_x_cm  = cx_in.cm;
      rsp_in.pos_y_cm  = cy_in.cm;
      rsp_in.saturated = sat5_ff || cx_in.sat || cy_in.sat;
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else       rsp_valid_ff <= v5_ff;
      rsp_item_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

FILE: sv/brbl_check.sv
module brbl_check
   import brbl_pkg::*;
#(
   parameter int FRAME_COLS = 1024,
   parameter int FRAME_ROWS = 768
) (
   input logic         clock,
   input logic         reset,
   input logic         start,
   input logic         busy,
   input logic         rsp_valid,
   input rsp_item_type rsp_item,
   input logic         csr_valid,
   input logic         csr_ready,
   input logic         csr_index,
   input logic [8:0]   csr_wdata
);

   localparam int LAT   = brbl_latency(FRAME_COLS, FRAME_ROWS);
   localparam int CNT_W = $clog2(LAT + 1);

   logic [CNT_W-1:0]  age_ff;
   logic signed [1:0] heading_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         age_ff     <= '0;
         heading_ff <= 2'sd1;
      end else begin
         if (age_ff != CNT_W'(LAT)) age_ff <= age_ff + 1'b1;
         if (csr_valid && csr_ready && csr_index == CSR_HEADING_SIGN) begin
            heading_ff <= csr_wdata[1:0];
         end
      end
   end

   // Every accepted item yields exactly one result once it has passed the whole pipeline.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (age_ff == CNT_W'(LAT)) |-> (rsp_valid == $past(start && !busy, LAT)))
      else $error("result strobe does not match accepted items");

   a_no_result_early: assert property (@(posedge clock) disable iff (reset)
      (age_ff != CNT_W'(LAT)) |-> !rsp_valid)
      else $error("result without an accepted item");

   // A zero heading sign forces both coordinates to zero.
   a_zero_heading: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && heading_ff == 2'sd0) |->
         (rsp_item.pos_x_cm == 16'sd0 && rsp_item.pos_y_cm == 16'sd0))
      else $error("nonzero position with zero heading sign");

endmodule

bind box_range_bearing_locator brbl_check #(
   .FRAME_COLS(FRAME_COLS),
   .FRAME_ROWS(FRAME_ROWS)
) u_brbl_check (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item),
   .csr_valid (csr_valid),
   .csr_ready (csr_ready),
   .csr_index (csr_index),
   .csr_wdata (csr_wdata)
);

FILE: bench/box_range_bearing_locator_tb.sv
module box_range_bearing_locator_tb;
   import brbl_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // The fourth mode code is not defined by the package. The block is expected
   // to treat it like height range with a center bearing.
   localparam logic [1:0] MODE_SPARE = 2'd3;
   localparam int PIPE_CYCLES = brbl_latency(1024, 768);

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   req_item_type req_item = '0;
   logic         rsp_valid;
   rsp_item_type rsp_item;
   logic         csr_valid = 1'b0;
   logic         csr_ready;
   logic         csr_index = 1'b0;
   logic [8:0]   csr_wdata = '0;

   box_range_bearing_locator u_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // This is the bench's own copy of the two registers. It follows every
   // write that the block accepts.
   longint offset_deg = 0;
   longint heading = 1;

   // These are the predicted positions, oldest first.
   rsp_item_type pending_positions[$];
   int  mismatches = 0;
   int  boxes_sent = 0;
   int  positions_seen = 0;
   int  saturated_seen = 0;
   bit  gaps_enabled = 1'b1;

   localparam longint CORDIC_ATAN [16] = '{
      2949120, 1740967, 919879, 466945, 234379, 117305, 58666, 29335,
      14668, 7334, 3667, 1833, 917, 458, 229, 115
   };

   // Scale the range by the trig value and the heading. The result is cut
   // toward zero to whole centimeters and clipped to 16 bits signed.
   function automatic logic signed [15:0] scale_to_cm(longint range_q8, longint trig,
                                                      ref bit clipped);
      longint v, mag;
      bit neg;
      v = range_q8 * trig * heading;
      neg = v < 0;
      mag = neg ? -v : v;
      mag = mag >> 38;
      if (!neg && mag > 32767) begin
         clipped = 1'b1;
         return 16'sh7FFF;
      end
      if (neg && mag > 32768) begin
         clipped = 1'b1;
         return 16'sh8000;
      end
      return neg ? 16'(-mag) : 16'(mag);
   endfunction

   // Compute the ground position of one box from the pinhole range and the
   // CORDIC sine and cosine of the bearing.
   function automatic rsp_item_type locate_box(req_item_type b);
      rsp_item_type r;
      longint k, dim, pix, range_q8, col, ang, z, x, y, dx, dy;
      bit clipped, flip;
      clipped = 1'b0;
      flip = 1'b0;
      if (b.mode == MODE_WIDTH_CENTER) begin
         k = 64233; dim = 1024; pix = b.box_width;
      end else begin
         k = 86169; dim = 768; pix = b.box_height;
      end
      if (pix == 0) begin
         range_q8 = 24'hFFFFFF;
         clipped = 1'b1;
      end else begin
         range_q8 = (k * longint'(b.real_size_cm) * dim) / (pix * 256);
         if (range_q8 > 24'hFFFFFF) begin
            range_q8 = 24'hFFFFFF;
            clipped = 1'b1;
         end
      end
      if (b.mode == MODE_HEIGHT_RIGHT)
         col = longint'(b.box_left) + longint'(b.box_width);
      else
         col = longint'(b.box_left) + longint'(b.box_width) / 2;
      ang = ((col - 512) * 13696) / 1024 + offset_deg * 256;
      // Wrap into one turn. Then fold into the front half plane. A fold
      // negates both sine and cosine.
      ang = ang % TURN_Q8;
      if (ang < 0) ang += TURN_Q8;
      if (ang > HALF_TURN_Q8) ang -= TURN_Q8;
      if (ang > QUARTER_TURN_Q8) begin
         ang -= HALF_TURN_Q8; flip = 1'b1;
      end else if (ang < -QUARTER_TURN_Q8) begin
         ang += HALF_TURN_Q8; flip = 1'b1;
      end
      z = ang * 256;
      x = 652032874;
      y = 0;
      for (int i = 0; i < 16; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx; y += dy; z -= CORDIC_ATAN[i];
         end else begin
            x += dx; y -= dy; z += CORDIC_ATAN[i];
         end
      end
      if (flip) begin
         x = -x; y = -y;
      end
      r.pos_x_cm = scale_to_cm(range_q8, y, clipped);
      r.pos_y_cm = scale_to_cm(range_q8, x, clipped);
      r.saturated = clipped;
      return r;
   endfunction

   // Every result on the result ports is compared with the oldest prediction.
   always @(posedge clock) begin
      rsp_item_type want;
      if (!reset && rsp_valid) begin
         positions_seen++;
         if (pending_positions.size() == 0) begin
            $error("result with no item outstanding: x=%0d y=%0d sat=%0d",
                   rsp_item.pos_x_cm, rsp_item.pos_y_cm, rsp_item.saturated);
            mismatches++;
         end else begin
            want = pending_positions.pop_front();
            if (rsp_item.saturated) saturated_seen++;
            if (rsp_item.pos_x_cm !== want.pos_x_cm) begin
               $error("pos_x_cm expected %0d actual %0d", want.pos_x_cm, rsp_item.pos_x_cm);
               mismatches++;
            end
            if (rsp_item.pos_y_cm !== want.pos_y_cm) begin
               $error("pos_y_cm expected %0d actual %0d", want.pos_y_cm, rsp_item.pos_y_cm);
               mismatches++;
            end
            if (rsp_item.saturated !== want.saturated) begin
               $error("saturated expected %0d actual %0d",
                      want.saturated, rsp_item.saturated);
               mismatches++;
            end
         end
      end
   end

   // Most gaps are zero or short. A few are long.
   function automatic int pick_gap();
      int roll;
      if (!gaps_enabled) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Present one box and hold start until the block takes it. Start is
   // lowered only when a gap follows, so back-to-back items keep it high.
   task automatic send_box(req_item_type b);
      int gap;
      req_item <= b;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      pending_positions.insert(pending_positions.size(), locate_box(b));
      boxes_sent++;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_fields(logic [1:0] m, logic [7:0] rs, logic [9:0] l,
                              logic [10:0] w, logic [9:0] h);
      req_item_type b;
      b.mode = m; b.real_size_cm = rs; b.box_left = l; b.box_width = w; b.box_height = h;
      send_box(b);
   endtask

   // Wait until every outstanding item has produced its result.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_positions.size() != 0) @(posedge clock);
   endtask

   // Registers are written only while the pipeline is empty.
   task automatic write_csr(logic idx, logic [8:0] data);
      drain();
      csr_index <= idx;
      csr_wdata <= data;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_BEARING_OFFSET)
         offset_deg = longint'($signed(data));
      else
         heading = longint'($signed(data[1:0]));
   endtask

   task automatic send_random_box();
      req_item_type b;
      b.mode = 2'($urandom_range(0, 3));
      b.real_size_cm = 8'($urandom);
      b.box_left = 10'($urandom);
      // Mostly realistic widths. Sometimes any 11-bit value is used.
      b.box_width = ($urandom_range(0, 3) == 0) ? 11'($urandom) : 11'($urandom_range(1, 400));
      b.box_height = ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(1, 300));
      send_box(b);
   endtask

   // These are the field extremes, every mode, and the corner cases: the
   // spare mode code, a zero pixel size, a zero real size and a range that
   // overflows.
   task automatic test_directed();
      send_fields(MODE_HEIGHT_CENTER, 8'd1,   10'd0,    11'd1,    10'd768);
      send_fields(MODE_HEIGHT_CENTER, 8'd255, 10'd1023, 11'd1024, 10'd1);
      send_fields(MODE_HEIGHT_RIGHT,  8'd170, 10'd1023, 11'd2047, 10'd100);
      send_fields(MODE_HEIGHT_RIGHT,  8'd30,  10'd0,    11'd1,    10'd1023);
      send_fields(MODE_WIDTH_CENTER,  8'd85,  10'd512,  11'd1,    10'd5);
      send_fields(MODE_WIDTH_CENTER,  8'd255, 10'd0,    11'd2047, 10'd0);
      send_fields(MODE_WIDTH_CENTER,  8'd200, 10'd300,  11'd0,    10'd50);
      send_fields(MODE_SPARE,         8'd40,  10'd700,  11'd64,   10'd120);
      send_fields(MODE_HEIGHT_CENTER, 8'd40,  10'd100,  11'd64,   10'd0);
      send_fields(MODE_HEIGHT_RIGHT,  8'd0,   10'd900,  11'd300,  10'd200);
      send_fields(MODE_WIDTH_CENTER,  8'd0,   10'd10,   11'd1365, 10'd682);
      send_fields(MODE_HEIGHT_CENTER, 8'd255, 10'd480,  11'd64,   10'd2);
      send_fields(MODE_HEIGHT_CENTER, 8'd100, 10'd511,  11'd2,    10'd341);
      send_fields(MODE_HEIGHT_RIGHT,  8'd60,  10'd341,  11'd682,  10'd512);
   endtask

   // Offsets are swept across the register range, including values past
   // half a turn. Heading values of one, zero, minus one and minus two are
   // used.
   task automatic test_register_sweep();
      int offsets [6] = '{0, 255, -256, 90, -90, 181};
      int headings [4] = '{1, 0, -1, -2};
      foreach (offsets[i]) begin
         write_csr(CSR_BEARING_OFFSET, 9'(offsets[i]));
         write_csr(CSR_HEADING_SIGN, 9'(headings[i % 4]));
         repeat (30) send_random_box();
      end
   endtask

   // This is the bulk random run. It has several register settings, one
   // stretch without any gaps, and pauses mid-phase until the pipeline is
   // empty.
   task automatic test_random_boxes();
      for (int phase = 0; phase < 10; phase++) begin
         write_csr(CSR_BEARING_OFFSET, 9'($urandom));
         write_csr(CSR_HEADING_SIGN, (phase % 3 == 0) ? 9'd1 : 9'($urandom));
         gaps_enabled = (phase != 4);
         for (int n = 0; n < 145; n++) begin
            if (n == 70) drain();
            send_random_box();
         end
      end
      gaps_enabled = 1'b1;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_register_sweep();
      test_random_boxes();
      drain();
      repeat (PIPE_CYCLES + 10) @(posedge clock);
      $display("Sent %0d boxes over 17 register settings; checked %0d positions, %0d clipped.",
               boxes_sent, positions_seen, saturated_seen);
      if (mismatches == 0 && pending_positions.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // This is the overall time limit. It is far above the slowest correct run.
   initial begin
      #4ms;
      $display("timeout with %0d items outstanding", pending_positions.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule

FILE: files.f
sv/brbl_pkg.sv
sv/brbl_div_cell.sv
sv/brbl_cordic_cell.sv
sv/box_range_bearing_locator.sv
sv/brbl_check.sv
bench/box_range_bearing_locator_tb.sv
